// ===== rtl/core/c3f_pkg.sv =====
package c3f_pkg;

   localparam int MaxWidth  = 2048;
   localparam int MaxHeight = 2048;
   localparam int CoefBits  = 8;
   localparam int AddrBits  = $clog2(MaxWidth);
   localparam int DimBits   = 12;
   localparam int PixBits   = 24;
   localparam int SumBits   = 20;
   localparam int ProdBits  = CoefBits + 9;

   // register indexes on the csr port
   localparam logic [2:0] REG_COEF_TOP = 3'd0;
   localparam logic [2:0] REG_COEF_MID = 3'd1;
   localparam logic [2:0] REG_COEF_BOT = 3'd2;
   localparam logic [2:0] REG_DIVISOR  = 3'd3;
   localparam logic [2:0] REG_WIDTH    = 3'd4;
   localparam logic [2:0] REG_HEIGHT   = 3'd5;

   typedef logic [PixBits-1:0] pixel_type;
   typedef logic signed [SumBits-1:0] sum_type;

   // clamp a programmed dimension to 3..max
   function automatic logic [DimBits-1:0] eff_dim(input logic [DimBits-1:0] v,
                                                  input logic [DimBits-1:0] hi);
      logic [DimBits-1:0] r;
      r = v;
      if (v < DimBits'(3)) r = DimBits'(3);
      else if (v > hi) r = hi;
      return r;
   endfunction

endpackage

// ===== rtl/core/c3f_if.sv =====
interface c3f_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] sample_red;
   logic [7:0] sample_green;
   logic [7:0] sample_blue;
   modport source (output valid, sample_red, sample_green, sample_blue, input ready);
   modport sink (input valid, sample_red, sample_green, sample_blue, output ready);
endinterface

interface c3f_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_red;
   logic [7:0]  out_green;
   logic [7:0]  out_blue;
   logic [10:0] out_row;
   logic [10:0] out_col;
   logic        frame_last;
   modport source (output valid, out_red, out_green, out_blue, out_row, out_col,
                   frame_last, input ready);
   modport sink (input valid, out_red, out_green, out_blue, out_row, out_col,
                 frame_last, output ready);
endinterface

// ===== rtl/core/c3f_div.sv =====
module c3f_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  c3f_pkg::sum_type    sum,
   input  logic [7:0]          divisor,
   output logic                done,
   output logic [7:0]          quotient
);

   logic [3:0] cnt_ff, cnt_in;
   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   logic       neg_ff;
   logic       sat_ff;
   logic [7:0] rem_ff;
   logic [7:0] low_ff;
   logic [7:0] q_ff;
   logic [8:0] trial;
   logic [8:0] diff;
   logic [15:0] limit;

   assign limit = {divisor, 8'd0};
   assign trial = {rem_ff, low_ff[7]};
   assign diff  = trial - {1'b0, divisor};

   // control: eight restoring steps after start
   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in  = 4'd8;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath: remainder starts at sum[15:8], which is sum / 256 and below the divisor unless saturated or negative
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= sum[c3f_pkg::SumBits-1];
         sat_ff <= !sum[c3f_pkg::SumBits-1] &&
                   (sum[c3f_pkg::SumBits-2:0] >= 19'(limit));
         rem_ff <= sum[15:8];
         low_ff <= sum[7:0];
         q_ff   <= '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_ff <= diff[7:0];
            q_ff   <= {q_ff[6:0], 1'b1};
         end else begin
            rem_ff <= trial[7:0];
            q_ff   <= {q_ff[6:0], 1'b0};
         end
         low_ff <= {low_ff[6:0], 1'b0};
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? 8'd0 : (sat_ff ? 8'd255 : q_ff);

endmodule

// ===== rtl/core/conv3x3_rgb_filter.sv =====
// 3x3 convolution over an rgb pixel stream, one word in flight at a time.
// an interior word passes window update, 9 taps, divider load, 8 divider steps
// and the output register, which waits while a previous result is not taken. a new
// word is accepted only in idle, after the last one has left; border words skip the
// taps and the divider. line stores hold garbage until written, no clear pass.
// reset is synchronous active high; it clears counters, window, state and output valid, and loads config defaults.
module conv3x3_rgb_filter (
   input  logic        clock,
   input  logic        reset,
   c3f_req_if.sink     req_ch,
   c3f_rsp_if.source   rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOAD = 3'd1;
   localparam logic [2:0] S_MAC  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_WAIT = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   localparam int DB = c3f_pkg::DimBits;
   localparam int AB = c3f_pkg::AddrBits;

   // config registers
   logic [23:0]   coef_top_ff, coef_mid_ff, coef_bot_ff;
   logic [7:0]    divisor_ff;
   logic [DB-1:0] width_ff, height_ff;
   logic [2:0]    reg_idx;
   logic          csr_wr;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_top_ff <= 24'h000000;
         coef_mid_ff <= 24'h010000;
         coef_bot_ff <= 24'h000000;
         divisor_ff  <= 8'd1;
         width_ff    <= DB'(640);
         height_ff   <= DB'(480);
      end else if (csr_wr) begin
         unique case (reg_idx)
            c3f_pkg::REG_COEF_TOP: coef_top_ff <= csr_pwdata[23:0];
            c3f_pkg::REG_COEF_MID: coef_mid_ff <= csr_pwdata[23:0];
            c3f_pkg::REG_COEF_BOT: coef_bot_ff <= csr_pwdata[23:0];
            c3f_pkg::REG_DIVISOR:  divisor_ff  <= csr_pwdata[7:0];
            c3f_pkg::REG_WIDTH:    width_ff    <= csr_pwdata[DB-1:0];
            c3f_pkg::REG_HEIGHT:   height_ff   <= csr_pwdata[DB-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (reg_idx)
         c3f_pkg::REG_COEF_TOP: csr_prdata = {8'd0, coef_top_ff};
         c3f_pkg::REG_COEF_MID: csr_prdata = {8'd0, coef_mid_ff};
         c3f_pkg::REG_COEF_BOT: csr_prdata = {8'd0, coef_bot_ff};
         c3f_pkg::REG_DIVISOR:  csr_prdata = {24'd0, divisor_ff};
         c3f_pkg::REG_WIDTH:    csr_prdata = {20'd0, width_ff};
         c3f_pkg::REG_HEIGHT:   csr_prdata = {20'd0, height_ff};
         default:               csr_prdata = 32'd0;
      endcase
   end

   // effective geometry
   logic [DB-1:0] eff_w, eff_h;
   assign eff_w = c3f_pkg::eff_dim(width_ff, DB'(c3f_pkg::MaxWidth));
   assign eff_h = c3f_pkg::eff_dim(height_ff, DB'(c3f_pkg::MaxHeight));

   logic [2:0]    state_ff, state_in;
   logic [DB-1:0] col_cnt_ff, col_cnt_in, row_cnt_ff, row_cnt_in;
   logic [DB-1:0] cur_col, cur_row, row_inc, col_inc, nrow_inc;
   logic [DB-1:0] col_ff, row_ff;
   logic          accept;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   // position of the incoming word, with wrap if geometry shrank
   always_comb begin
      cur_col = col_cnt_ff;
      cur_row = row_cnt_ff;
      row_inc = row_cnt_ff + DB'(1);
      if (col_cnt_ff >= eff_w) begin
         cur_col = '0;
         cur_row = row_inc;
      end
      if (cur_row >= eff_h) cur_row = '0;
      col_inc  = cur_col + DB'(1);
      nrow_inc = cur_row + DB'(1);
      col_cnt_in = col_inc;
      row_cnt_in = cur_row;
      if (col_inc >= eff_w) begin
         col_cnt_in = '0;
         row_cnt_in = (nrow_inc >= eff_h) ? '0 : nrow_inc;
      end
   end

   // line stores
   c3f_pkg::pixel_type upper_mem [c3f_pkg::MaxWidth];
   c3f_pkg::pixel_type lower_mem [c3f_pkg::MaxWidth];
   c3f_pkg::pixel_type upper_rd_ff, lower_rd_ff, pix_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         upper_rd_ff <= upper_mem[cur_col[AB-1:0]];
         lower_rd_ff <= lower_mem[cur_col[AB-1:0]];
      end
      if (state_ff == S_LOAD) begin
         upper_mem[col_ff[AB-1:0]] <= lower_rd_ff;
         lower_mem[col_ff[AB-1:0]] <= pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff <= {req_ch.sample_blue, req_ch.sample_green, req_ch.sample_red};
         col_ff <= cur_col;
         row_ff <= cur_row;
      end
   end

   // window: [column oldest..newest][top, mid, bottom]
   c3f_pkg::pixel_type win_ff [3][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++)
            for (int r = 0; r < 3; r++)
               win_ff[k][r] <= '0;
      end else if (state_ff == S_LOAD) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2][0] <= upper_rd_ff;
         win_ff[2][1] <= lower_rd_ff;
         win_ff[2][2] <= pix_ff;
      end
   end

   // tap loop, three planes at once
   logic [1:0]  tap_r_ff, tap_c_ff;
   logic [23:0] coef_row;
   logic signed [c3f_pkg::CoefBits-1:0] coef;
   c3f_pkg::pixel_type tap_pix;
   c3f_pkg::sum_type acc_ff [3];
   logic signed [c3f_pkg::ProdBits-1:0] prod [3];
   logic        interior;
   logic        last_tap;

   assign interior = (row_ff >= DB'(2)) && (col_ff >= DB'(2));
   assign last_tap = (tap_r_ff == 2'd2) && (tap_c_ff == 2'd2);

   always_comb begin
      case (tap_r_ff)
         2'd0:    coef_row = coef_top_ff;
         2'd1:    coef_row = coef_mid_ff;
         default: coef_row = coef_bot_ff;
      endcase
      case (tap_c_ff)
         2'd0:    coef = coef_row[7:0];
         2'd1:    coef = coef_row[15:8];
         default: coef = coef_row[23:16];
      endcase
      tap_pix = win_ff[tap_c_ff][tap_r_ff];
      for (int p = 0; p < 3; p++)
         prod[p] = $signed({1'b0, tap_pix[p*8 +: 8]}) * coef;
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_LOAD) begin
         tap_r_ff <= 2'd0;
         tap_c_ff <= 2'd0;
         for (int p = 0; p < 3; p++) acc_ff[p] <= '0;
      end else if (state_ff == S_MAC) begin
         if (tap_c_ff == 2'd2) begin
            tap_c_ff <= 2'd0;
            tap_r_ff <= tap_r_ff + 2'd1;
         end else begin
            tap_c_ff <= tap_c_ff + 2'd1;
         end
         for (int p = 0; p < 3; p++)
            acc_ff[p] <= acc_ff[p] + c3f_pkg::SumBits'(prod[p]);
      end
   end

   // dividers
   logic [7:0] div_eff;
   logic       div_start;
   logic [2:0] div_done;
   logic [7:0] quot [3];

   assign div_eff   = (divisor_ff == 8'd0) ? 8'd1 : divisor_ff;
   assign div_start = (state_ff == S_DIV);

   for (genvar p = 0; p < 3; p++) begin : g_div
      c3f_div u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (div_start),
         .sum      (acc_ff[p]),
         .divisor  (div_eff),
         .done     (div_done[p]),
         .quotient (quot[p])
      );
   end

   // output register
   logic        out_valid_ff;
   logic [7:0]  out_r_ff, out_g_ff, out_b_ff;
   logic [10:0] out_row_ff, out_col_ff;
   logic        out_last_ff;
   logic        out_load;

   assign out_load = (state_ff == S_OUT) && (!out_valid_ff || rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (out_load) out_valid_ff <= 1'b1;
      else if (rsp_ch.ready) out_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_r_ff    <= quot[0];
         out_g_ff    <= quot[1];
         out_b_ff    <= quot[2];
         out_row_ff  <= 11'(row_ff - DB'(1));
         out_col_ff  <= 11'(col_ff - DB'(1));
         out_last_ff <= (row_ff == eff_h - DB'(1)) && (col_ff == eff_w - DB'(1));
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.out_red    = out_r_ff;
   assign rsp_ch.out_green  = out_g_ff;
   assign rsp_ch.out_blue   = out_b_ff;
   assign rsp_ch.out_row    = out_row_ff;
   assign rsp_ch.out_col    = out_col_ff;
   assign rsp_ch.frame_last = out_last_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_LOAD;
         S_LOAD: state_in = interior ? S_MAC : S_IDLE;
         S_MAC:  if (last_tap) state_in = S_DIV;
         S_DIV:  state_in = S_WAIT;
         S_WAIT: if (div_done[0]) state_in = S_OUT;
         S_OUT:  if (out_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            col_cnt_ff <= col_cnt_in;
            row_cnt_ff <= row_cnt_in;
         end
      end
   end

endmodule
